// ===== rtl/core/acr_pkg.sv =====
// acr_pkg: item types, command codes and widths for the alphabet compaction remap block.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package acr_pkg;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int VAL_W   = 8;
  localparam int SIZE_W  = 9;

  // Popcount grouping: map bits are counted in groups of 16, two halves of 8
  localparam int GROUP_W = 16;
  localparam int GCNT_W  = 5;
  localparam int QUAD_N  = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MAP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] byte_value;
  } acr_in_t;

  typedef struct packed {
    logic [VAL_W-1:0]  mapped_value;
    logic [SIZE_W-1:0] alphabet_size;
  } acr_out_t;

  // Control carried from the map stage to the rank stage
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] size;
  } acr_stage_t;

  // Population count of eight bits
  function automatic logic [3:0] popcnt8(input logic [7:0] bits);
    logic [3:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      acc = acc + {3'd0, bits[k]};
    end
    return acc;
  endfunction

endpackage

// ===== rtl/core/acr_map.sv =====
// acr_map: presence map flops, alphabet size counter and per-group rank popcounts.
// Depends on acr_pkg.
`timescale 1ns / 1ps

module acr_map #(
  parameter int SYMBOL_COUNT = 256,
  parameter int NGROUPS      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 item_valid,
  input  acr_pkg::acr_in_t                     item,
  output acr_pkg::acr_stage_t                  stage,
  output logic [NGROUPS-1:0][acr_pkg::GCNT_W-1:0] partials
);
  import acr_pkg::*;

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int PAD_W = NGROUPS * GROUP_W;

  logic [SYMBOL_COUNT-1:0] map_r, map_nxt;
  logic [SIZE_W-1:0]       count_r, count_nxt;
  logic                    valid_r;
  logic [SIZE_W-1:0]       size_r;
  logic [NGROUPS-1:0][GCNT_W-1:0] partials_r, partials_nxt;

  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic             hit;
  logic             mark_new;
  logic             do_clear;
  logic             do_rank;
  logic [PAD_W-1:0] map_pad;
  logic [PAD_W-1:0] sel;

  // Decode the item against the current map
  assign in_range = {1'b0, item.byte_value} < SIZE_W'(SYMBOL_COUNT);
  assign idx      = item.byte_value[IDX_W-1:0];
  assign hit      = in_range && map_r[idx];
  assign mark_new = item_valid && (item.command == CMD_MARK) && in_range && !map_r[idx];
  assign do_clear = item_valid && (item.command == CMD_CLEAR);
  assign do_rank  = item_valid && (item.command == CMD_MAP) && hit;

  // Map and size update
  always_comb begin
    map_nxt   = map_r;
    count_nxt = count_r;
    if (mark_new) begin
      map_nxt[idx] = 1'b1;
      count_nxt    = count_r + SIZE_W'(1);
    end
    if (do_clear) begin
      map_nxt   = '0;
      count_nxt = '0;
    end
  end

  // Present bytes at or below the requested one
  assign map_pad = PAD_W'(map_r);
  always_comb begin
    for (int i = 0; i < PAD_W; i++) begin
      sel[i] = map_pad[i] && (SIZE_W'(i) <= {1'b0, item.byte_value});
    end
  end

  // Group popcounts, zero unless this is a map of a present byte
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      if (do_rank) begin
        partials_nxt[g] = {1'b0, popcnt8(sel[g*GROUP_W +: 8])}
                        + {1'b0, popcnt8(sel[g*GROUP_W+8 +: 8])};
      end else begin
        partials_nxt[g] = '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r   <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      map_r   <= map_nxt;
      count_r <= count_nxt;
      valid_r <= item_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    size_r     <= count_nxt;
    partials_r <= partials_nxt;
  end

  assign stage    = '{valid: valid_r, size: size_r};
  assign partials = partials_r;

endmodule

// ===== rtl/core/acr_rank.sv =====
// acr_rank: sums the group popcounts into the compact code and registers the result.
// Depends on acr_pkg.
`timescale 1ns / 1ps

module acr_rank #(
  parameter int NGROUPS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  acr_pkg::acr_stage_t                     stage,
  input  logic [NGROUPS-1:0][acr_pkg::GCNT_W-1:0] partials,
  output logic                                    res_strobe,
  output acr_pkg::acr_out_t                       res_item
);
  import acr_pkg::*;

  localparam int NQUADS = (NGROUPS + QUAD_N - 1) / QUAD_N;

  logic [NQUADS*QUAD_N-1:0][GCNT_W-1:0] part_pad;
  logic [NQUADS-1:0][SIZE_W-1:0]        quad_sum;
  logic [SIZE_W-1:0]                    rank;
  logic                                 strobe_r;
  acr_out_t                             item_r, item_nxt;

  assign part_pad = (NQUADS*QUAD_N*GCNT_W)'(partials);

  // Two-level adder tree: groups of four, then the quads
  always_comb begin
    for (int q = 0; q < NQUADS; q++) begin
      quad_sum[q] = '0;
      for (int k = 0; k < QUAD_N; k++) begin
        quad_sum[q] = quad_sum[q] + SIZE_W'(part_pad[q*QUAD_N + k]);
      end
    end
  end

  always_comb begin
    rank = '0;
    for (int q = 0; q < NQUADS; q++) begin
      rank = rank + quad_sum[q];
    end
  end

  // Rank is truncated to eight bits
  always_comb begin
    item_nxt.mapped_value  = rank[VAL_W-1:0];
    item_nxt.alphabet_size = stage.size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign res_strobe = strobe_r;
  assign res_item   = item_r;

endmodule

// ===== rtl/core/alphabet_compaction_remap_top.sv =====
// alphabet_compaction_remap_top: input register, presence map stage and rank stage.
// Depends on acr_pkg, acr_map and acr_rank.
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+------------------------------------
//  input    | start, busy, in_item        | taken on a clock edge with start=1
//  result   | out_strobe, out_item        | one cycle per result, no backpressure
//
// One item per clock; busy stays low. Each result passes through the input
// register, the map update and group popcounts, then the adder tree into the
// result register. Synchronous reset clears the presence map and alphabet
// size. The receiver cannot stall the block.
`timescale 1ns / 1ps

module alphabet_compaction_remap_top #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  acr_pkg::acr_in_t   in_item,
  output logic               out_strobe,
  output acr_pkg::acr_out_t  out_item
);
  import acr_pkg::*;

  localparam int NGROUPS = (SYMBOL_COUNT + GROUP_W - 1) / GROUP_W;

  logic       accept;
  logic       in_valid_r;
  acr_in_t    in_item_r;
  acr_stage_t stage;
  logic [NGROUPS-1:0][GCNT_W-1:0] partials;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item;
  end

  acr_map #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .NGROUPS      (NGROUPS)
  ) u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (in_item_r),
    .stage      (stage),
    .partials   (partials)
  );

  acr_rank #(
    .NGROUPS (NGROUPS)
  ) u_rank (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .partials   (partials),
    .res_strobe (out_strobe),
    .res_item   (out_item)
  );

`ifndef SYNTHESIS
  // Every item taken gives a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_strobe)
    else $error("result missing three cycles after item");

  // A clear reports an empty alphabet
  a_clear_size: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.command == CMD_CLEAR) |-> ##3 (out_item.alphabet_size == '0))
    else $error("clear did not empty the alphabet");

  // A mark of a byte in the alphabet leaves it non-empty
  a_mark_size: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.command == CMD_MARK &&
     ({1'b0, in_item.byte_value} < SIZE_W'(SYMBOL_COUNT)))
    |-> ##3 (out_item.alphabet_size != '0))
    else $error("mark left the alphabet empty");

  // Only a map item yields a nonzero code
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.command != CMD_MAP) |-> ##3 (out_item.mapped_value == '0))
    else $error("nonzero code for a non-map item");
`endif

endmodule
